// ===== hw/rtl/fsdi_pkg.sv =====
// fsdi_pkg: shared types and constants for the scaled decimal converter
// no dependencies
package fsdi_pkg;
    localparam int unsigned FRAC_BITS = 52;
    localparam int unsigned SIG_BITS = 53;
    localparam int unsigned PROD_BITS = 63;
    localparam logic [9:0] ODD_FACTOR = 10'd625;
    localparam logic [11:0] SHIFT_BIAS = 12'd1071;
    localparam logic [10:0] EXP_MAX = 11'h7FF;
    localparam logic [63:0] MAG_CEILING = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        zero;
        logic        neg;
        logic        right;
        logic [11:0] amount;
    } fsdi_ctl_t;
endpackage

// ===== hw/rtl/fsdi_shift.sv =====
// fsdi_shift: shift and round half-even or saturating left shift of the product
// depends on fsdi_pkg
module fsdi_shift
    import fsdi_pkg::*;
(
    input  logic [PROD_BITS-1:0] prod,
    input  fsdi_ctl_t            ctl,
    output logic [63:0]          mag
);
    logic [126:0] wide;
    logic [63:0]  q;
    logic [63:0]  rem_mask;
    logic [63:0]  half;
    logic [63:0]  rem;
    logic         up;
    logic [126:0] lsh;
    logic [6:0]   amt;

    assign amt = ctl.amount[6:0];

    always_comb
    begin
        wide = {64'd0, prod};
        q = 64'(wide >> amt);
        rem_mask = (64'd1 << amt) - 64'd1;
        rem = {1'b0, prod} & rem_mask;
        half = (amt == 7'd0) ? 64'd0 : (64'd1 << (amt - 7'd1));
        up = (amt != 7'd0) && ((rem > half) || ((rem == half) && q[0]));
        lsh = wide << amt;
        if (ctl.zero)
            mag = 64'd0;
        else if (ctl.right)
            mag = q + {63'd0, up};
        else if (ctl.amount >= 12'd64 || lsh[126:63] != 64'd0)
            mag = MAG_CEILING;
        else
            mag = lsh[63:0];
    end
endmodule

// ===== hw/rtl/float_to_scaled_decimal_int.sv =====
// float_to_scaled_decimal_int: binary64 pattern to value*10^4, round half-even
// depends on fsdi_pkg, fsdi_shift
//
// one request per cycle unless stalled; pipeline stages: decode, multiply by 625, shift
// and round, sign and output register; stall freezes the whole pipe
module float_to_scaled_decimal_int
    import fsdi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] value_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [63:0] scaled_value
);
    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic [SIG_BITS-1:0]  sig_reg;
    fsdi_ctl_t            ctl1_reg, ctl2_reg;
    fsdi_ctl_t            ctl_next;
    logic [PROD_BITS-1:0] prod_reg;
    logic [63:0]          mag_reg, mag_next;
    logic                 neg3_reg;
    logic [63:0]          res_reg;
    logic                 adv;
    logic [10:0]          bexp;
    logic [12:0]          diff;

    // global enable: pipe moves unless output is held
    assign adv = !(v4_reg && out_stall);
    assign in_stall = !adv;

    // decode: right shift amount = 1071 - exponent, sign tells direction
    always_comb
    begin
        bexp = value_bits[62:52];
        diff = {1'b0, SHIFT_BIAS} - {2'b0, bexp};
        ctl_next.neg = value_bits[63];
        ctl_next.right = !diff[12] && diff != 13'd0;
        ctl_next.amount = diff[12] ? 12'(-diff) : diff[11:0];
        ctl_next.zero = bexp == 11'd0 || bexp == EXP_MAX || (!diff[12] && diff >= 13'd64);
    end

    fsdi_shift u_shift (.prod(prod_reg), .ctl(ctl2_reg), .mag(mag_next));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sig_reg  <= {1'b1, value_bits[51:0]};
            ctl1_reg <= ctl_next;
            // significand times the odd part of ten thousand
            prod_reg <= PROD_BITS'({10'd0, sig_reg} * ODD_FACTOR);
            ctl2_reg <= ctl1_reg;
            mag_reg  <= mag_next;
            neg3_reg <= ctl2_reg.neg;
            res_reg  <= neg3_reg ? (64'd0 - mag_reg) : mag_reg;
        end
    end

    assign out_valid = v4_reg;
    assign scaled_value = res_reg;
endmodule
